// ===== design/qse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quicksort engine.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned DataW    = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_POP,
    ST_POP_WAIT,
    ST_PIV_RD,
    ST_PIV_WAIT,
    ST_I_RD,
    ST_I_WAIT,
    ST_J_RD,
    ST_J_WAIT,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_FIN_WR0,
    ST_FIN_WRJ,
    ST_PUSH_HI,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_e;

  // Signed less-than on two's complement words.
  function automatic logic less_than(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    less_than = $signed(a) < $signed(b);
  endfunction

endpackage

// ===== design/quicksort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects signed words, sorts them in place by quicksort and streams them out.
// ----------------------------------------------------------------------------
// Elements are loaded one beat per cycle into a 64-entry element memory; up to
// 64 are kept, and any beyond that are dropped and reported through the
// overflowed flag of every result of that set. The beat marked last_item starts
// the sort; no input beat is taken from then until the last result beat is
// delivered. Sorting is an in-place quicksort with the first element of each
// range as pivot and a range stack held in a second memory. Both memories have
// one registered read port, so every element comparison needs a read state
// and a wait state and every swap takes two writes. Each element is then read
// out through the OUT_RD, OUT_WAIT and OUT_HOLD states, and OUT_HOLD holds on
// an output stall. The result beats carry the value, its rank, a flag on the
// final one and the overflow flag.
module quicksort_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] value_i,
  input  logic        last_item_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] sorted_value_o,
  output logic [5:0]  position_o,
  output logic        last_result_o,
  output logic        overflowed_o
);

  // Element and range-stack memories, synchronous read.
  logic [31:0] elem_mem [qse_pkg::MaxItems];
  logic [11:0] stk_mem  [qse_pkg::MaxItems];

  qse_pkg::state_e state_q, state_d;
  qse_pkg::cnt_t   count_q, count_d;
  qse_pkg::cnt_t   sp_q, sp_d;
  logic            ovf_q, ovf_d;
  qse_pkg::idx_t   lo_q, lo_d, hi_q, hi_d;
  qse_pkg::cnt_t   i_q, i_d, j_q, j_d;
  logic [31:0]     piv_q, piv_d;
  logic [31:0]     vi_q, vi_d;
  qse_pkg::cnt_t   k_q, k_d;
  logic [31:0]     out_q, out_d;

  // Memory port controls.
  logic          e_we, e_re;
  qse_pkg::idx_t e_wa, e_ra;
  logic [31:0]   e_wd, e_rd_q;
  logic          s_we, s_re;
  qse_pkg::idx_t s_wa, s_ra;
  logic [11:0]   s_wd, s_rd_q;

  always_ff @(posedge clk_i) begin
    if (e_we) elem_mem[e_wa] <= e_wd;
    if (e_re) e_rd_q <= elem_mem[e_ra];
    if (s_we) stk_mem[s_wa] <= s_wd;
    if (s_re) s_rd_q <= stk_mem[s_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qse_pkg::ST_LOAD;
      count_q <= '0;
      sp_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    piv_q <= piv_d;
    vi_q  <= vi_d;
    k_q   <= k_d;
    out_q <= out_d;
  end

  logic in_acc;
  assign stall_o = (state_q != qse_pkg::ST_LOAD);
  assign in_acc  = valid_i && !stall_o;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sp_d    = sp_q;
    ovf_d   = ovf_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    piv_d   = piv_q;
    vi_d    = vi_q;
    k_d     = k_q;
    out_d   = out_q;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_re = 1'b0; e_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_re = 1'b0; s_ra = '0;
    valid_o = 1'b0;

    case (state_q)
      qse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_q < qse_pkg::CntW'(qse_pkg::MaxItems)) begin
            e_we    = 1'b1;
            e_wa    = count_q[qse_pkg::IdxW-1:0];
            e_wd    = value_i;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            // Count after this beat decides whether there is work to do.
            sp_d = '0;
            k_d  = '0;
            if (count_d >= qse_pkg::CntW'(2)) begin
              s_we = 1'b1;
              s_wa = '0;
              s_wd = {6'(count_d - 1'b1), 6'd0};
              sp_d = qse_pkg::CntW'(1);
              state_d = qse_pkg::ST_POP;
            end else begin
              state_d = qse_pkg::ST_OUT_RD;
            end
          end
        end
      end

      qse_pkg::ST_POP: begin
        if (sp_q == '0) begin
          k_d = '0;
          state_d = qse_pkg::ST_OUT_RD;
        end else begin
          s_re = 1'b1;
          s_ra = 6'(sp_q - 1'b1);
          sp_d = sp_q - 1'b1;
          state_d = qse_pkg::ST_POP_WAIT;
        end
      end

      qse_pkg::ST_POP_WAIT: begin
        lo_d = s_rd_q[5:0];
        hi_d = s_rd_q[11:6];
        if (s_rd_q[11:6] <= s_rd_q[5:0]) state_d = qse_pkg::ST_POP;
        else state_d = qse_pkg::ST_PIV_RD;
      end

      qse_pkg::ST_PIV_RD: begin
        e_re = 1'b1;
        e_ra = lo_q;
        i_d  = {1'b0, lo_q};
        j_d  = {1'b0, hi_q} + 1'b1;
        state_d = qse_pkg::ST_PIV_WAIT;
      end

      qse_pkg::ST_PIV_WAIT: begin
        piv_d = e_rd_q;
        state_d = qse_pkg::ST_I_RD;
      end

      // Scan upward from the left.
      qse_pkg::ST_I_RD: begin
        i_d  = i_q + 1'b1;
        e_re = 1'b1;
        e_ra = 6'(i_q + 1'b1);
        state_d = qse_pkg::ST_I_WAIT;
      end

      qse_pkg::ST_I_WAIT: begin
        vi_d = e_rd_q;
        if (qse_pkg::less_than(e_rd_q, piv_q) && i_q[5:0] != hi_q) state_d = qse_pkg::ST_I_RD;
        else state_d = qse_pkg::ST_J_RD;
      end

      // Scan downward from the right.
      qse_pkg::ST_J_RD: begin
        j_d  = j_q - 1'b1;
        e_re = 1'b1;
        e_ra = 6'(j_q - 1'b1);
        state_d = qse_pkg::ST_J_WAIT;
      end

      qse_pkg::ST_J_WAIT: begin
        if (qse_pkg::less_than(piv_q, e_rd_q) && j_q[5:0] != lo_q) begin
          state_d = qse_pkg::ST_J_RD;
        end else if (i_q >= j_q) begin
          state_d = qse_pkg::ST_FIN_RD;
        end else begin
          // Element j goes to slot i now; element i to slot j next cycle.
          e_we = 1'b1;
          e_wa = i_q[5:0];
          e_wd = e_rd_q;
          state_d = qse_pkg::ST_SWAP_J;
        end
      end

      qse_pkg::ST_SWAP_J: begin
        e_we = 1'b1;
        e_wa = j_q[5:0];
        e_wd = vi_q;
        state_d = qse_pkg::ST_I_RD;
      end

      qse_pkg::ST_FIN_RD: begin
        e_re = 1'b1;
        e_ra = j_q[5:0];
        state_d = qse_pkg::ST_FIN_WAIT;
      end

      qse_pkg::ST_FIN_WAIT: begin
        // Pivot (still held) moves to j, element j to the range start.
        e_we = 1'b1;
        e_wa = lo_q;
        e_wd = e_rd_q;
        state_d = qse_pkg::ST_FIN_WRJ;
      end

      qse_pkg::ST_FIN_WRJ: begin
        e_we = 1'b1;
        e_wa = j_q[5:0];
        e_wd = piv_q;
        if (j_q > {1'b0, lo_q} + 1'b1 && sp_q < qse_pkg::CntW'(qse_pkg::MaxItems)) begin
          s_we = 1'b1;
          s_wa = sp_q[5:0];
          s_wd = {6'(j_q - 1'b1), lo_q};
          sp_d = sp_q + 1'b1;
        end
        state_d = qse_pkg::ST_PUSH_HI;
      end

      qse_pkg::ST_PUSH_HI: begin
        if ({1'b0, hi_q} > j_q + 1'b1 && sp_q < qse_pkg::CntW'(qse_pkg::MaxItems)) begin
          s_we = 1'b1;
          s_wa = sp_q[5:0];
          s_wd = {hi_q, 6'(j_q + 1'b1)};
          sp_d = sp_q + 1'b1;
        end
        state_d = qse_pkg::ST_POP;
      end

      qse_pkg::ST_OUT_RD: begin
        if (k_q >= count_q) begin
          count_d = '0;
          sp_d    = '0;
          ovf_d   = 1'b0;
          state_d = qse_pkg::ST_LOAD;
        end else begin
          e_re = 1'b1;
          e_ra = k_q[5:0];
          state_d = qse_pkg::ST_OUT_WAIT;
        end
      end

      qse_pkg::ST_OUT_WAIT: begin
        out_d = e_rd_q;
        state_d = qse_pkg::ST_OUT_HOLD;
      end

      qse_pkg::ST_OUT_HOLD: begin
        valid_o = 1'b1;
        if (!stall_i) begin
          k_d = k_q + 1'b1;
          state_d = qse_pkg::ST_OUT_RD;
        end
      end

      default: state_d = qse_pkg::ST_LOAD;
    endcase
  end

  assign sorted_value_o = out_q;
  assign position_o     = k_q[5:0];
  assign last_result_o  = (k_q + 1'b1 == count_q);
  assign overflowed_o   = ovf_q;

endmodule
